>>> design/div128_pkg.sv
`timescale 1ns / 1ps

package div128_pkg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture operands and check the range
        logic step;     // retire one quotient bit
        logic finish;   // move the result into the output register
    } div128_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic err;      // operands give a quotient that does not fit
        logic out_full; // output register holds an untaken result
    } div128_status_t;

endpackage

>>> design/div128_ctrl.sv
`timescale 1ns / 1ps

module div128_ctrl
    import div128_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           out_stall,
    input  div128_status_t status,
    output div128_cmd_t    cmd
);

    localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORD_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_free;

    // The output slot is free when empty or being drained this cycle
    assign out_free = !status.out_full || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    count_next = '0;
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (status.err)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (count_reg == LAST_CNT)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> design/div128_dp.sv
`timescale 1ns / 1ps

module div128_dp
    import div128_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  div128_cmd_t          cmd,
    output div128_status_t       status,
    input  logic [WORD_BITS-1:0] dividend_high,
    input  logic [WORD_BITS-1:0] dividend_low,
    input  logic [WORD_BITS-1:0] divisor,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [WORD_BITS-1:0] quotient,
    output logic [WORD_BITS-1:0] remainder,
    output logic                 overflow_error
);

    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] ql_reg;   // low dividend bits out the top, quotient bits in
    logic [WORD_BITS-1:0] div_reg;
    logic                 err_reg;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] quo_out_reg;
    logic [WORD_BITS-1:0] rem_out_reg;
    logic                 err_out_reg;

    logic [WORD_BITS-1:0] shifted;
    logic [WORD_BITS+1:0] diff;
    logic                 take;
    logic                 range_err;

    assign range_err = (divisor == '0) || (dividend_high >= divisor);

    // Partial remainder shifted left with the next dividend bit; carry-out kept in the top
    assign shifted = {rem_reg[WORD_BITS-2:0], ql_reg[WORD_BITS-1]};
    assign diff    = {1'b0, rem_reg[WORD_BITS-1], shifted} - {2'b00, div_reg};
    assign take    = !diff[WORD_BITS+1];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= dividend_high;
            ql_reg  <= dividend_low;
            div_reg <= divisor;
            err_reg <= range_err;
        end
        else if (cmd.step)
        begin
            rem_reg <= take ? diff[WORD_BITS-1:0] : shifted;
            ql_reg  <= {ql_reg[WORD_BITS-2:0], take};
        end

        if (cmd.finish)
        begin
            quo_out_reg <= err_reg ? '0 : ql_reg;
            rem_out_reg <= err_reg ? '0 : rem_reg;
            err_out_reg <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.err      = err_reg;
    assign status.out_full = out_valid_reg;

    assign out_valid      = out_valid_reg;
    assign quotient       = quo_out_reg;
    assign remainder      = rem_out_reg;
    assign overflow_error = err_out_reg;

endmodule

>>> design/divide_128_by_64.sv
`timescale 1ns / 1ps

// Unsigned double-word by single-word divider. The dividend is
// dividend_high:dividend_low (2*WORD_BITS bits) and the divisor is one word;
// the result is a one-word quotient and remainder. When the divisor is zero
// or dividend_high is not below the divisor the quotient would not fit, so
// overflow_error is raised and quotient and remainder return as zero. The
// block works on one transaction at a time. A normal transaction runs the
// restoring shift-and-subtract loop, which retires one quotient bit per
// cycle, and then loads the output register once that register is free. A
// new transaction is not accepted until the last one has been moved into
// the output register. An out-of-range transaction skips the loop. in_stall
// is low only while the divider is idle. A finished result sits in the
// output register until taken, and the next transaction may be accepted
// meanwhile.
module divide_128_by_64
    import div128_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_BITS-1:0] dividend_high,
    input  logic [WORD_BITS-1:0] dividend_low,
    input  logic [WORD_BITS-1:0] divisor,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_BITS-1:0] quotient,
    output logic [WORD_BITS-1:0] remainder,
    output logic                 overflow_error
);

    div128_cmd_t    cmd;
    div128_status_t status;

    // Sequencer: accept, iterate one bit per cycle, hand off to the output
    div128_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Operand registers, remainder/quotient shift registers and output register
    div128_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .dividend_high  (dividend_high),
        .dividend_low   (dividend_low),
        .divisor        (divisor),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .quotient       (quotient),
        .remainder      (remainder),
        .overflow_error (overflow_error)
    );

endmodule

>>> tb/division_checker.sv
`timescale 1ns / 1ps

module division_checker #(
    parameter int WORD_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [WORD_BITS-1:0] dividend_high,
    input  logic [WORD_BITS-1:0] dividend_low,
    input  logic [WORD_BITS-1:0] divisor,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [WORD_BITS-1:0] quotient,
    input  logic [WORD_BITS-1:0] remainder,
    input  logic                 overflow_error,
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        logic [WORD_BITS-1:0] quo;
        logic [WORD_BITS-1:0] rem;
        logic                 ovf;
    } division_t;

    division_t pending_quotients[$];

    // Exact double-word division; the quotient fits whenever high < divisor.
    function automatic division_t predict_division(
        input logic [WORD_BITS-1:0] hi,
        input logic [WORD_BITS-1:0] lo,
        input logic [WORD_BITS-1:0] d
    );
        logic [2*WORD_BITS-1:0] num;
        logic [2*WORD_BITS-1:0] wide_d;
        division_t res;
        num = {hi, lo};
        wide_d = {{WORD_BITS{1'b0}}, d};
        if (d == '0 || hi >= d) begin
            res.quo = '0;
            res.rem = '0;
            res.ovf = 1'b1;
        end else begin
            res.quo = WORD_BITS'(num / wide_d);
            res.rem = WORD_BITS'(num % wide_d);
            res.ovf = 1'b0;
        end
        return res;
    endfunction

    always @(posedge clk) begin
        division_t want;
        if (!rst_n) begin
            mismatches = 0;
            outstanding <= 0;
            pending_quotients.delete();
        end else begin
            // Retire the result first: a new operand may arrive in the same cycle.
            if (out_valid && !out_stall) begin
                if (pending_quotients.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: result with no transaction pending: q=%h r=%h err=%b",
                                 $realtime, quotient, remainder, overflow_error);
                end else begin
                    want = pending_quotients.pop_front();
                    if (quotient !== want.quo || remainder !== want.rem
                        || overflow_error !== want.ovf) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: q=%h/%h r=%h/%h err=%b/%b (got/want)",
                                     $realtime, quotient, want.quo, remainder, want.rem,
                                     overflow_error, want.ovf);
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_quotients.push_back(
                    predict_division(dividend_high, dividend_low, divisor));
            outstanding <= pending_quotients.size();
        end
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int WORD_BITS  = 64;
    localparam int RAND_ITEMS = 1150;
    // Allow well over ten times the slowest transaction plus the longest gap
    // and stall with nothing moving.
    localparam int IDLE_LIMIT = 2000;

    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;
    localparam logic [WORD_BITS-1:0] TOP_ONE  = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [WORD_BITS-1:0] dividend_high;
    logic [WORD_BITS-1:0] dividend_low;
    logic [WORD_BITS-1:0] divisor;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [WORD_BITS-1:0] quotient;
    logic [WORD_BITS-1:0] remainder;
    logic                 overflow_error;

    logic no_idle = 1'b0;   // when set, neither side inserts gaps or stalls
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   mismatches;
    int   outstanding;

    wire in_accept  = in_valid && !in_stall;
    wire out_accept = out_valid && !out_stall;

    divide_128_by_64 #(
        .WORD_BITS(WORD_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .dividend_high (dividend_high),
        .dividend_low  (dividend_low),
        .divisor       (divisor),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .quotient      (quotient),
        .remainder     (remainder),
        .overflow_error(overflow_error)
    );

    division_checker #(
        .WORD_BITS(WORD_BITS)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .dividend_high (dividend_high),
        .dividend_low  (dividend_low),
        .divisor       (divisor),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .quotient      (quotient),
        .remainder     (remainder),
        .overflow_error(overflow_error),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: after each taken result, hold stall high for a random
    // number of cycles (none while no_idle is set).
    always @(posedge clk)
    begin
        int n;
        if (out_accept)
        begin
            n = no_idle ? 0 : $urandom_range(0, 6);
            stall_left <= n;
            out_stall  <= (n != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || in_accept || out_accept)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("** divide_128_by_64: FAILED **");
            $finish;
        end
    end

    function automatic logic [WORD_BITS-1:0] rand_word();
        return WORD_BITS'({$urandom, $urandom});
    endfunction

    // Present one transaction after a random gap and hold it until accepted.
    // A zero gap keeps in_valid high straight into the next transaction.
    task automatic send_division(
        input logic [WORD_BITS-1:0] hi,
        input logic [WORD_BITS-1:0] lo,
        input logic [WORD_BITS-1:0] d
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        dividend_high <= hi;
        dividend_low  <= lo;
        divisor       <= d;
        do
            @(posedge clk);
        while (!in_accept);
    endtask

    // Drop valid and hold off until every predicted result has been taken.
    // The first edge lets the checker count the transaction just accepted.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Draw one random transaction: mostly in-range divisions over a wide
    // spread of divisor sizes, with some zero divisors and high-word overflows.
    task automatic send_random_division();
        logic [WORD_BITS-1:0] hi;
        logic [WORD_BITS-1:0] lo;
        logic [WORD_BITS-1:0] d;
        int kind;
        kind = $urandom_range(0, 99);
        lo = rand_word();
        if ($urandom_range(0, 19) == 0)
            lo = $urandom_range(0, 1) ? ALL_ONES : '0;
        if (kind < 6)
        begin
            d  = '0;
            hi = rand_word();
        end
        else if (kind < 14)
        begin
            // high word at or above the divisor; a divisor of one spans the whole word
            d = rand_word() >> $urandom_range(0, WORD_BITS - 1);
            if (d == '0)
                d = WORD_BITS'(1);
            if (d == WORD_BITS'(1))
                hi = rand_word() | WORD_BITS'(1);
            else
                hi = d + (rand_word() % (ALL_ONES - d + WORD_BITS'(1)));
        end
        else
        begin
            if (kind < 34)
                d = rand_word() | TOP_ONE;
            else
                d = rand_word() >> $urandom_range(0, WORD_BITS - 1);
            if (d == '0)
                d = WORD_BITS'(1);
            case ($urandom_range(0, 7))
                0:       hi = d - 1;
                1:       hi = '0;
                default: hi = rand_word() % d;
            endcase
        end
        send_division(hi, lo, d);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        dividend_high <= '0;
        dividend_low  <= '0;
        divisor       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero divisor, high word equal to or above the divisor,
        // field extremes, and the carry out of the top bit.
        send_division('0, '0, '0);
        send_division(ALL_ONES, ALL_ONES, '0);
        send_division(64'd5, 64'd77, 64'd5);
        send_division(ALL_ONES, '0, ALL_ONES);
        send_division(ALL_ONES, ALL_ONES, 64'd1);
        send_division(64'd1, '0, 64'd1);
        send_division(64'd2, 64'd9, 64'd1);
        send_division('0, '0, 64'd1);
        send_division('0, ALL_ONES, 64'd1);
        send_division(ALL_ONES - 1, ALL_ONES, ALL_ONES);
        send_division('0, ALL_ONES, ALL_ONES);
        send_division('0, '0, ALL_ONES);
        send_division(TOP_ONE - 1, ALL_ONES, TOP_ONE);
        send_division(TOP_ONE, '0, ALL_ONES);
        send_division('0, TOP_ONE, TOP_ONE);
        send_division(64'd1, '0, 64'd2);
        send_division(64'd2, ALL_ONES, 64'd3);
        send_division('0, 64'd123456789, 64'd1000);
        send_division(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                      64'hAAAA_AAAA_AAAA_AAAA);
        send_division(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                      64'h8000_0000_0000_0001);

        // Hold off the sender until the pipeline is empty at least once.
        drain_results();

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            // Advance into a new idling pattern every 64 transactions.
            if (i % 64 == 0)
                no_idle <= ($urandom_range(0, 3) == 0);
            if (i % 97 == 50 && $urandom_range(0, 1) == 0)
                drain_results();
            send_random_division();
        end

        drain_results();
        repeat (WORD_BITS + 10) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("** divide_128_by_64: PASSED **");
        else
            $display("** divide_128_by_64: FAILED **");
        $finish;
    end

endmodule

>>> divide_128_by_64.f
design/div128_pkg.sv
design/div128_ctrl.sv
design/div128_dp.sv
design/divide_128_by_64.sv
tb/division_checker.sv
tb/tb.sv
